>>> hdl/mprs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mprs_pkg;

	localparam int ADDRESS_BITS   = 19;
	localparam int LANES          = 16;
	localparam int EDGES_PER_NODE = 8;

	localparam int STORE_DEPTH = 1 << ADDRESS_BITS;
	localparam int CNT_W       = $clog2(EDGES_PER_NODE + 1);
	localparam int LANE_W      = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_RELAX  = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic signed [31:0] POT_INF = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] POT_MIN = 32'sh8000_0000;

	typedef logic [ADDRESS_BITS-1:0] addr_t;
	typedef logic signed [31:0]      pot_t;
	typedef logic [LANES-1:0]        mask_t;

	// one classified item as queued between front and back
	typedef struct packed {
		logic [1:0]        kind;
		addr_t             node;
		addr_t             target;
		pot_t              value;      // write value or edge weight
		logic              sink_valid;
		pot_t              sink_value;
		logic              last_edge;
		logic [LANE_W-1:0] lane;
		logic              last_lane;
	} op_t;

	typedef struct packed {
		logic [LANE_W-1:0] lane;
		logic              changed;
		pot_t              potential;
		mask_t             mask;
		logic              mask_valid;
	} result_t;

	// saturating Q16.16 add; an infinite potential stays infinite
	function automatic pot_t sat_add(pot_t pot, pot_t w);
		logic signed [32:0] s;
		s = $signed({pot[31], pot}) + $signed({w[31], w});
		if (pot == POT_INF)
			return POT_INF;
		if (s >= 33'sh0_7FFF_FFFF)
			return POT_INF;
		if (s < 33'sh1_8000_0000)
			return POT_MIN;
		return s[31:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/mprs_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface mprs_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [18:0]        node_index;
	logic signed [31:0] write_value;
	logic [18:0]        target_index;
	logic signed [31:0] edge_weight;
	logic               sink_valid;
	logic signed [31:0] sink_value;
	logic               last_edge;
	logic [3:0]         lane;
	logic               last_lane;

	modport source (
		output valid, kind, node_index, write_value, target_index, edge_weight,
		output sink_valid, sink_value, last_edge, lane, last_lane,
		input  ready
	);
	modport sink (
		input  valid, kind, node_index, write_value, target_index, edge_weight,
		input  sink_valid, sink_value, last_edge, lane, last_lane,
		output ready
	);
endinterface

interface mprs_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         lane_out;
	logic               changed;
	logic signed [31:0] potential_out;
	logic [15:0]        changed_mask;
	logic               mask_valid;

	modport source (
		output valid, lane_out, changed, potential_out, changed_mask, mask_valid,
		input  ready
	);
	modport sink (
		input  valid, lane_out, changed, potential_out, changed_mask, mask_valid,
		output ready
	);
endinterface

interface mprs_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hdl/mprs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mprs_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	mprs_in_if.sink           req,
	output mprs_pkg::op_t     push_op,
	output logic              push_valid,
	input  wire logic         push_ready
);

	logic          v_s1;
	mprs_pkg::op_t op_s1;
	mprs_pkg::op_t op_d;

	assign req.ready = !v_s1 || push_ready;

	always_comb begin
		op_d.kind       = req.kind;
		op_d.node       = req.node_index[mprs_pkg::ADDRESS_BITS-1:0];
		op_d.target     = req.target_index[mprs_pkg::ADDRESS_BITS-1:0];
		op_d.value      = (req.kind == mprs_pkg::KIND_WRITE) ? req.write_value
		                                                     : req.edge_weight;
		op_d.sink_valid = req.sink_valid;
		op_d.sink_value = req.sink_value;
		op_d.last_edge  = req.last_edge;
		op_d.lane       = req.lane;
		op_d.last_lane  = req.last_lane;
	end

	// unused kind is dropped here and never reaches the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid && (req.kind != mprs_pkg::KIND_UNUSED);
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			op_s1 <= op_d;
	end

	assign push_valid = v_s1;
	assign push_op    = op_s1;

endmodule

`default_nettype wire

>>> hdl/mprs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mprs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mprs_pkg::op_t  push_op,
	input  wire logic           push_valid,
	output logic                push_ready,
	output mprs_pkg::op_t       pop_op,
	output logic                pop_valid,
	input  wire logic           pop_ready
);

	mprs_pkg::op_t                ent_q [mprs_pkg::QUEUE_DEPTH];
	logic [mprs_pkg::QPTR_W-1:0]  wr_q;
	logic [mprs_pkg::QPTR_W-1:0]  rd_q;
	logic [mprs_pkg::QPTR_W:0]    cnt_q;
	logic                         push;
	logic                         pop;

	assign push_ready = cnt_q != (mprs_pkg::QPTR_W + 1)'(mprs_pkg::QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_op     = ent_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + mprs_pkg::QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + mprs_pkg::QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (mprs_pkg::QPTR_W + 1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (mprs_pkg::QPTR_W + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_op;
	end

endmodule

`default_nettype wire

>>> hdl/mprs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mprs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [15:0]    eps,
	input  wire mprs_pkg::op_t  q_op,
	input  wire logic           q_valid,
	output logic                q_ready,
	mprs_out_if.source          rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EDGE = 2'd1;  // target potential in rdata_q
	localparam logic [1:0] ST_NODE = 2'd2;  // node potential in rdata_q
	localparam logic [1:0] ST_READ = 2'd3;

	logic [1:0]                  state_q, state_d;
	mprs_pkg::op_t               op_q;
	mprs_pkg::pot_t              store_q [mprs_pkg::STORE_DEPTH];
	mprs_pkg::pot_t              rdata_q;
	mprs_pkg::pot_t              min_q, min_d;
	logic [mprs_pkg::CNT_W-1:0]  cnt_q, cnt_d;
	mprs_pkg::mask_t             mask_q, mask_d;
	logic                        out_v_q;
	mprs_pkg::result_t           res_q, res_d;
	logic                        out_load;
	logic                        out_free;

	logic                        mem_we;
	logic                        mem_re;
	mprs_pkg::addr_t             mem_addr;
	mprs_pkg::pot_t              mem_wdata;

	mprs_pkg::pot_t              sum;
	mprs_pkg::pot_t              cand;
	logic signed [32:0]          diff;
	logic                        lower;
	mprs_pkg::mask_t             lane_bit;
	mprs_pkg::mask_t             mask_new;

	assign out_free = !out_v_q || rsp.ready;
	assign q_ready  = state_q == ST_IDLE;

	assign sum      = mprs_pkg::sat_add(rdata_q, op_q.value);
	assign cand     = op_q.sink_valid ? op_q.sink_value : min_q;
	assign diff     = $signed({rdata_q[31], rdata_q}) - $signed({cand[31], cand});
	assign lower    = diff > $signed({17'd0, eps});
	assign lane_bit = (int'(op_q.lane) < mprs_pkg::LANES)
	                  ? (mprs_pkg::mask_t'(1) << op_q.lane) : '0;
	assign mask_new = lower ? (mask_q | lane_bit) : mask_q;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = op_q.node;
		mem_wdata = cand;
		min_d     = min_q;
		cnt_d     = cnt_q;
		mask_d    = mask_q;
		out_load  = 1'b0;
		res_d     = '0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_op.kind)
						mprs_pkg::KIND_WRITE: begin
							mem_we    = 1'b1;
							mem_addr  = q_op.node;
							mem_wdata = q_op.value;
						end
						mprs_pkg::KIND_READ: begin
							mem_re   = 1'b1;
							mem_addr = q_op.node;
							state_d  = ST_READ;
						end
						mprs_pkg::KIND_RELAX: begin
							mem_re   = 1'b1;
							mem_addr = q_op.target;
							state_d  = ST_EDGE;
						end
						default: ;
					endcase
				end
			end
			ST_EDGE: begin
				// edges beyond the per-node limit are not folded in
				if (cnt_q < mprs_pkg::CNT_W'(mprs_pkg::EDGES_PER_NODE)) begin
					if (sum < min_q)
						min_d = sum;
					cnt_d = cnt_q + mprs_pkg::CNT_W'(1);
				end
				if (op_q.last_edge) begin
					mem_re  = 1'b1;
					state_d = ST_NODE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_NODE: begin
				if (out_free) begin
					mem_we          = lower;
					out_load        = 1'b1;
					res_d.lane      = op_q.lane;
					res_d.changed   = lower;
					res_d.potential = lower ? cand : rdata_q;
					res_d.mask      = op_q.last_lane ? mask_new : '0;
					res_d.mask_valid = op_q.last_lane;
					mask_d          = op_q.last_lane ? '0 : mask_new;
					min_d           = mprs_pkg::POT_INF;
					cnt_d           = '0;
					state_d         = ST_IDLE;
				end
			end
			ST_READ: begin
				if (out_free) begin
					out_load        = 1'b1;
					res_d.potential = rdata_q;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_q   <= mprs_pkg::POT_INF;
			cnt_q   <= '0;
			mask_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			min_q   <= min_d;
			cnt_q   <= cnt_d;
			mask_q  <= mask_d;
			if (out_load)
				out_v_q <= 1'b1;
			else if (rsp.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready)
			op_q <= q_op;
		if (out_load)
			res_q <= res_d;
	end

	// single-port store, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			store_q[mem_addr] <= mem_wdata;
		if (mem_re)
			rdata_q <= store_q[mem_addr];
	end

	assign rsp.valid         = out_v_q;
	assign rsp.lane_out      = res_q.lane;
	assign rsp.changed       = res_q.changed;
	assign rsp.potential_out = res_q.potential;
	assign rsp.changed_mask  = res_q.mask;
	assign rsp.mask_valid    = res_q.mask_valid;

`ifndef SYNTHESIS
	a_node_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NODE && out_free) |=> (min_q == mprs_pkg::POT_INF && cnt_q == '0))
		else $error("running minimum not cleared at end of node");

	a_batch_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NODE && out_free && op_q.last_lane)
		|=> (mask_q == '0 && rsp.valid && rsp.mask_valid))
		else $error("batch mask not emitted and cleared on last lane");

	a_mask_zero_unless_final: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.mask_valid) |-> (rsp.changed_mask == '0))
		else $error("changed mask shown while not final");

	a_edge_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EDGE) |-> ($past(state_q) == ST_IDLE))
		else $error("edge evaluation without a preceding target read");
`endif

endmodule

`default_nettype wire

>>> hdl/min_plus_relaxation_sweep_unit.sv
// An item is registered in the front end and queued before the back end works on it and
// registers the result; queued work ahead of an item delays it further.
// The back end takes no new item until it is idle again; in the single-port store a relax
// edge is a target read, a node's last edge a target read, node read and write-back.
// Reset: arst_n clears control, running minimum (infinity), batch mask and epsilon at once;
// the potential store is not cleared and holds nothing defined until written.
`timescale 1ns / 1ps
`default_nettype none

module min_plus_relaxation_sweep_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mprs_in_if.sink    req,
	mprs_out_if.source rsp,
	mprs_cfg_if.sink   cfg
);

	logic [15:0]   eps_q;
	mprs_pkg::op_t push_op;
	logic          push_valid;
	logic          push_ready;
	mprs_pkg::op_t q_op;
	logic          q_valid;
	logic          q_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			eps_q <= cfg.data;
		end
	end

	mprs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_op    (push_op),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	mprs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_op    (push_op),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_op     (q_op),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	mprs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.eps     (eps_q),
		.q_op    (q_op),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int DRAIN_CYCLES = 40;
	localparam int POOL_SIZE    = 32;

	typedef struct {
		logic [1:0]       kind;
		mprs_pkg::addr_t  node_index;
		mprs_pkg::pot_t   write_value;
		mprs_pkg::addr_t  target_index;
		mprs_pkg::pot_t   edge_weight;
		logic             sink_valid;
		mprs_pkg::pot_t   sink_value;
		logic             last_edge;
		logic [3:0]       lane;
		logic             last_lane;
	} req_item_t;

	// keeps its own copy of the potentials and predicts each item's result
	class potential_tracker;
		mprs_pkg::pot_t    pots [mprs_pkg::addr_t];
		mprs_pkg::pot_t    run_min;
		mprs_pkg::mask_t   lane_mask;
		int unsigned       edges_seen;
		logic [15:0]       epsilon;
		mprs_pkg::result_t due_results [$];
		int                errors;

		function new();
			run_min    = mprs_pkg::POT_INF;
			lane_mask  = '0;
			edges_seen = 0;
			epsilon    = '0;
			errors     = 0;
		endfunction

		function mprs_pkg::pot_t saturate_sum(mprs_pkg::pot_t p, mprs_pkg::pot_t w);
			longint s;
			if (p == mprs_pkg::POT_INF)
				return mprs_pkg::POT_INF;
			s = longint'(p) + longint'(w);
			if (s >= longint'(mprs_pkg::POT_INF))
				return mprs_pkg::POT_INF;
			if (s < longint'(mprs_pkg::POT_MIN))
				return mprs_pkg::POT_MIN;
			return s[31:0];
		endfunction

		function void note_item(req_item_t it);
			mprs_pkg::result_t r;
			mprs_pkg::pot_t    s;
			mprs_pkg::pot_t    cand;
			mprs_pkg::pot_t    cur;
			r = '0;
			case (it.kind)
				mprs_pkg::KIND_WRITE: pots[it.node_index] = it.write_value;
				mprs_pkg::KIND_READ: begin
					r.potential = pots[it.node_index];
					due_results.push_back(r);
				end
				mprs_pkg::KIND_RELAX: begin
					// edges past the per-node limit are not folded in
					if (edges_seen < mprs_pkg::EDGES_PER_NODE) begin
						s = saturate_sum(pots[it.target_index], it.edge_weight);
						if (s < run_min)
							run_min = s;
						edges_seen++;
					end
					if (it.last_edge) begin
						cand = it.sink_valid ? it.sink_value : run_min;
						cur  = pots[it.node_index];
						r.lane      = it.lane;
						r.potential = cur;
						if (longint'(cur) - longint'(cand) > longint'(epsilon)) begin
							pots[it.node_index] = cand;
							r.potential = cand;
							r.changed   = 1'b1;
							if (it.lane < mprs_pkg::LANES)
								lane_mask[it.lane] = 1'b1;
						end
						run_min    = mprs_pkg::POT_INF;
						edges_seen = 0;
						if (it.last_lane) begin
							r.mask       = lane_mask;
							r.mask_valid = 1'b1;
							lane_mask    = '0;
						end
						due_results.push_back(r);
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %h got %h", $time, name, want, got);
			end
		endfunction

		function void check_result(mprs_pkg::result_t got);
			mprs_pkg::result_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display({"%0t: unexpected result, expected none got lane %0d changed %0d",
					" pot %h mask %h/%0d"},
					$time, got.lane, got.changed, got.potential, got.mask, got.mask_valid);
				return;
			end
			want = due_results.pop_front();
			compare_field("lane_out", 32'(want.lane), 32'(got.lane));
			compare_field("changed", 32'(want.changed), 32'(got.changed));
			compare_field("potential_out", want.potential, got.potential);
			compare_field("changed_mask", 32'(want.mask), 32'(got.mask));
			compare_field("mask_valid", 32'(want.mask_valid), 32'(got.mask_valid));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mprs_in_if  req ();
	mprs_out_if rsp ();
	mprs_cfg_if cfg ();

	min_plus_relaxation_sweep_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	potential_tracker model;
	int               gap_pct;
	int               stall_pct;
	int               items_sent;
	mprs_pkg::addr_t  node_pool [POOL_SIZE];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		mprs_pkg::result_t got;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.lane       = rsp.lane_out;
				got.changed    = rsp.changed;
				got.potential  = rsp.potential_out;
				got.mask       = rsp.changed_mask;
				got.mask_valid = rsp.mask_valid;
				model.check_result(got);
			end
			rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic req_item_t random_fields();
		req_item_t it;
		it.kind         = 2'($urandom_range(0, 3));
		it.node_index   = mprs_pkg::addr_t'($urandom);
		it.write_value  = $urandom;
		it.target_index = mprs_pkg::addr_t'($urandom);
		it.edge_weight  = $urandom;
		it.sink_valid   = 1'($urandom_range(0, 1));
		it.sink_value   = $urandom;
		it.last_edge    = 1'($urandom_range(0, 1));
		it.lane         = 4'($urandom_range(0, 15));
		it.last_lane    = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic mprs_pkg::pot_t rand_potential();
		case ($urandom_range(0, 9))
			0: return mprs_pkg::POT_INF;
			1: return mprs_pkg::POT_MIN;
			2: return mprs_pkg::POT_INF - 1;
			3, 4: return $urandom;
			default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
		endcase
	endfunction

	function automatic mprs_pkg::pot_t rand_weight();
		case ($urandom_range(0, 9))
			0: return mprs_pkg::POT_INF;
			1: return mprs_pkg::POT_MIN;
			2: return 0;
			3: return $urandom;
			default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
		endcase
	endfunction

	function automatic mprs_pkg::addr_t pool_addr();
		return node_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	function automatic req_item_t relax_item(mprs_pkg::addr_t node, mprs_pkg::addr_t target,
		mprs_pkg::pot_t weight, bit last);
		req_item_t it;
		it              = random_fields();
		it.kind         = mprs_pkg::KIND_RELAX;
		it.node_index   = node;
		it.target_index = target;
		it.edge_weight  = weight;
		it.last_edge    = last;
		it.sink_valid   = 1'b0;
		it.lane         = '0;
		it.last_lane    = 1'b0;
		return it;
	endfunction

	task automatic send_item(input req_item_t it);
		while ($urandom_range(0, 99) < gap_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid        <= 1'b1;
		req.kind         <= it.kind;
		req.node_index   <= it.node_index;
		req.write_value  <= it.write_value;
		req.target_index <= it.target_index;
		req.edge_weight  <= it.edge_weight;
		req.sink_valid   <= it.sink_valid;
		req.sink_value   <= it.sink_value;
		req.last_edge    <= it.last_edge;
		req.lane         <= it.lane;
		req.last_lane    <= it.last_lane;
		do @(posedge clk); while (!req.ready);
		model.note_item(it);
		if (it.kind != mprs_pkg::KIND_UNUSED)
			items_sent++;
	endtask

	task automatic write_pot(input mprs_pkg::addr_t node, input mprs_pkg::pot_t value);
		req_item_t it;
		it             = random_fields();
		it.kind        = mprs_pkg::KIND_WRITE;
		it.node_index  = node;
		it.write_value = value;
		send_item(it);
	endtask

	task automatic read_pot(input mprs_pkg::addr_t node);
		req_item_t it;
		it            = random_fields();
		it.kind       = mprs_pkg::KIND_READ;
		it.node_index = node;
		send_item(it);
	endtask

	// one node: its edges, now and then a stray write or read in between
	task automatic random_node(input logic [3:0] lane_no, input bit end_batch);
		req_item_t       it;
		mprs_pkg::addr_t node;
		int              n;
		n    = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 12))
		                                   : int'($urandom_range(1, 8));
		node = pool_addr();
		for (int e = 0; e < n; e++) begin
			if ($urandom_range(0, 19) == 0) begin
				if ($urandom_range(0, 1))
					write_pot(pool_addr(), rand_potential());
				else
					read_pot(pool_addr());
			end
			it = relax_item(node, pool_addr(), rand_weight(), e == n - 1);
			if (e == n - 1) begin
				it.sink_valid = ($urandom_range(0, 4) == 0);
				if (it.sink_valid)
					it.sink_value = rand_potential();
				it.lane      = lane_no;
				it.last_lane = end_batch;
			end else begin
				// ignored on inner edges, so left random
				it.node_index = mprs_pkg::addr_t'($urandom);
				it.sink_valid = 1'($urandom_range(0, 1));
				it.lane       = 4'($urandom_range(0, 15));
				it.last_lane  = 1'($urandom_range(0, 1));
			end
			send_item(it);
		end
	endtask

	// no result marks the end of write items, hence the extra cycles
	task automatic drain_results();
		req.valid <= 1'b0;
		while (model.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_epsilon(input logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		model.epsilon = value;
	endtask

	initial begin
		req_item_t   it;
		int          lane_no;
		int          batch_len;
		int          roll;
		int          goal;
		logic [15:0] eps;

		model      = new();
		gap_pct    = 0;
		stall_pct  = 0;
		items_sent = 0;
		arst_n     = 1'b0;
		req.valid        <= 1'b0;
		req.kind         <= mprs_pkg::KIND_WRITE;
		req.node_index   <= '0;
		req.write_value  <= '0;
		req.target_index <= '0;
		req.edge_weight  <= '0;
		req.sink_valid   <= 1'b0;
		req.sink_value   <= '0;
		req.last_edge    <= 1'b0;
		req.lane         <= '0;
		req.last_lane    <= 1'b0;
		cfg.valid        <= 1'b0;
		cfg.data         <= '0;

		node_pool[0] = '0;
		node_pool[1] = '1;
		node_pool[2] = 19'h2AAAA;
		node_pool[3] = 19'h55555;
		for (int i = 4; i < POOL_SIZE; i++)
			node_pool[i] = mprs_pkg::addr_t'($urandom_range(0, mprs_pkg::STORE_DEPTH - 1));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, epsilon still at its reset value
		write_pot(19'h00000, 32'sh0010_0000);
		write_pot(19'h7FFFF, mprs_pkg::POT_INF);
		write_pot(19'h2AAAA, mprs_pkg::POT_MIN);
		write_pot(19'h55555, mprs_pkg::POT_INF - 1);
		it = random_fields();
		it.kind = mprs_pkg::KIND_UNUSED;
		send_item(it);
		// infinite target, overflowing sum, underflowing sum, plain sum
		send_item(relax_item(19'h55555, 19'h7FFFF, -5, 1'b0));
		send_item(relax_item(19'h55555, 19'h00000, mprs_pkg::POT_INF, 1'b0));
		send_item(relax_item(19'h55555, 19'h2AAAA, mprs_pkg::POT_MIN, 1'b0));
		send_item(relax_item(19'h55555, 19'h00000, 0, 1'b1));
		// a write in the middle of a node keeps the running minimum
		send_item(relax_item(19'h00000, 19'h2AAAA, 1, 1'b0));
		write_pot(19'h2AAAA, 5);
		it = relax_item(19'h00000, 19'h2AAAA, 0, 1'b1);
		it.lane      = 15;
		it.last_lane = 1'b1;
		send_item(it);
		// infinite sink on an infinite node changes nothing
		it = relax_item(19'h7FFFF, 19'h00000, 0, 1'b1);
		it.sink_valid = 1'b1;
		it.sink_value = mprs_pkg::POT_INF;
		it.lane       = 3;
		send_item(it);
		// finite sink wins over the edge minimum
		it = relax_item(19'h2AAAA, 19'h00000, mprs_pkg::POT_MIN, 1'b1);
		it.sink_valid = 1'b1;
		it.sink_value = -3;
		it.lane       = 1;
		it.last_lane  = 1'b1;
		send_item(it);
		read_pot(19'h2AAAA);
		// ten edges: the last two would win but lie past the limit
		for (int e = 0; e < 10; e++) begin
			if (e < 8)
				it = relax_item(19'h7FFFF, 19'h55555, 32'sh0001_0000, 1'b0);
			else
				it = relax_item(19'h7FFFF, 19'h2AAAA, mprs_pkg::POT_MIN, e == 9);
			it.lane      = 2;
			it.last_lane = 1'b1;
			send_item(it);
		end

		for (int i = 4; i < POOL_SIZE; i++)
			write_pot(node_pool[i], rand_potential());

		lane_no   = 0;
		batch_len = $urandom_range(1, 16);
		for (int p = 0; p < 8; p++) begin
			drain_results();
			case (p)
				0, 5: eps = 16'hFFFF;
				1: eps = 16'h0000;
				3: eps = 16'h0001;
				default: eps = 16'($urandom_range(0, 65535));
			endcase
			write_epsilon(eps);
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 62; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 62; end
				default: begin gap_pct = 34; stall_pct = 34; end
			endcase
			goal = items_sent + 238;
			while (items_sent < goal) begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					random_node(4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : lane_no),
						lane_no == batch_len - 1);
					if (lane_no == batch_len - 1) begin
						lane_no   = 0;
						batch_len = $urandom_range(1, 16);
					end else begin
						lane_no++;
					end
				end else if (roll < 82) begin
					write_pot(pool_addr(), rand_potential());
				end else if (roll < 95) begin
					read_pot(pool_addr());
				end else begin
					it = random_fields();
					it.kind = mprs_pkg::KIND_UNUSED;
					send_item(it);
				end
			end
		end

		drain_results();
		if (model.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> files.f
hdl/mprs_pkg.sv
hdl/mprs_ifs.sv
hdl/mprs_front.sv
hdl/mprs_queue.sv
hdl/mprs_back.sv
hdl/min_plus_relaxation_sweep_unit.sv
dv/testbench.sv
